>>> sv/rtc3w_pkg.sv
// Shared types, codes and helpers for the three-wire clock-chip byte master.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rtc3w_pkg;

  // Input command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Access phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_SETUP = 4'd1;
  localparam logic [3:0] PH_HIGH  = 4'd2;
  localparam logic [3:0] PH_LOW   = 4'd3;
  localparam logic [3:0] PH_HOLD  = 4'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SETUP = 2'd0;
  localparam logic [1:0] CFG_HIGH  = 2'd1;
  localparam logic [1:0] CFG_LOW   = 2'd2;
  localparam logic [1:0] CFG_HOLD  = 2'd3;

  localparam logic [5:0] ADDR_MASK     = 6'h3f;
  localparam logic [7:0] CMD_BYTE_RD   = 8'h81;
  localparam logic [7:0] CMD_BYTE_WR   = 8'h80;
  localparam logic [4:0] BITS_PER_BYTE = 5'd8;
  localparam logic [4:0] BITS_PER_ACC  = 5'd16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] reg_addr;
    logic [7:0] write_data;
    logic       io_sample;
  } rtc3w_item_t;

  typedef struct packed {
    logic       enable_pin;
    logic       clock_pin;
    logic       io_drive_level;
    logic       io_driving;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } rtc3w_result_t;

  typedef struct packed {
    logic [7:0] setup_ticks;
    logic [7:0] high_ticks;
    logic [7:0] low_ticks;
    logic [7:0] hold_ticks;
  } rtc3w_cfg_t;

  // A zero tick count counts as one tick.
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

>>> sv/three_wire_rtc_byte_master.sv
// Top level of the three-wire clock-chip byte master: config registers,
// input register, access sequencer and result register. Depends on rtc3w_pkg,
// rtc3w_in_reg and rtc3w_core.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------
//  in_*     | slave     | in_tvalid/in_tready | tuser cmd, tdata address/data/pin
//  out_*    | master    | out_tvalid/tready   | tdata pin levels and status
//  cfg_*    | write     | cfg_we              | cfg_index, cfg_wdata
//
// Every transaction on the input gives exactly one result transaction, via the
// input register and then the result register. One transaction per cycle is
// sustained while the output is not stalled: the sequencer does one whole step
// between the two registers. A stalled output holds the result register; the
// input register keeps accepting as long as the result register can drain.
// Synchronous active-low reset idles the sequencer and loads the default
// tick counts (setup 4, clock high 1, clock low 1, hold 4).

module three_wire_rtc_byte_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [15:0] in_tdata,   // [5:0] reg_addr, [13:6] write_data, [14] io_sample, [15] 0
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] enable_pin, [1] clock_pin, [2] io_drive_level, [3] io_driving,
  // [4] busy_res, [5] done_res, [13:6] read_byte, [14] rejected, [15] 0
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import rtc3w_pkg::*;

  rtc3w_cfg_t    cfg_r;
  rtc3w_item_t   in_item;
  rtc3w_item_t   held_item;
  rtc3w_result_t step_result;
  rtc3w_result_t result_r;
  logic          held_valid;
  logic          take;
  logic          out_valid_r;

  // Configuration writes land directly in the tick count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks <= 8'd4;
      cfg_r.high_ticks  <= 8'd1;
      cfg_r.low_ticks   <= 8'd1;
      cfg_r.hold_ticks  <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETUP: cfg_r.setup_ticks <= cfg_wdata;
        CFG_HIGH:  cfg_r.high_ticks  <= cfg_wdata;
        CFG_LOW:   cfg_r.low_ticks   <= cfg_wdata;
        default:   cfg_r.hold_ticks  <= cfg_wdata;
      endcase
    end
  end

  // Unpack the input transaction
  assign in_item.cmd        = in_tuser;
  assign in_item.reg_addr   = in_tdata[5:0];
  assign in_item.write_data = in_tdata[13:6];
  assign in_item.io_sample  = in_tdata[14];

  rtc3w_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Advance the sequencer only when the result register is free or draining
  assign take = held_valid && (!out_valid_r || out_tready);

  rtc3w_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .item    (held_item),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, result_r.rejected, result_r.read_byte, result_r.done_res,
                       result_r.busy_res, result_r.io_driving, result_r.io_drive_level,
                       result_r.clock_pin, result_r.enable_pin};

endmodule

>>> sv/rtc3w_in_reg.sv
// Input register of the byte master: holds one accepted item until the core takes it.
// Depends on rtc3w_pkg.
`timescale 1ns / 1ps

module rtc3w_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtc3w_pkg::rtc3w_item_t in_item,
  input  logic                 take,
  output logic                 held_valid,
  output rtc3w_pkg::rtc3w_item_t held_item
);
  import rtc3w_pkg::*;

  logic        valid_r;
  rtc3w_item_t item_r;

  // Refill in the same cycle the held item is taken
  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> sv/rtc3w_core.sv
// Access sequencer: pin state registers and the one-step next-state logic.
// Depends on rtc3w_pkg.
`timescale 1ns / 1ps

module rtc3w_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  rtc3w_pkg::rtc3w_item_t item,
  input  rtc3w_pkg::rtc3w_cfg_t  cfg,
  output rtc3w_pkg::rtc3w_result_t result
);
  import rtc3w_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  wait_timer_r, wait_timer_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [15:0] tx_shift_r, tx_shift_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic        is_read_r, is_read_nxt;
  logic        enable_r, enable_nxt;
  logic        clock_r, clock_nxt;
  logic        data_r, data_nxt;
  logic        driving_r, driving_nxt;
  logic [7:0]  last_read_r, last_read_nxt;

  logic        rejected;
  logic        done;
  logic        start_bit;
  logic [4:0]  bit_idx;
  logic [7:0]  timer_dec;

  assign timer_dec = wait_timer_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    wait_timer_nxt = wait_timer_r;
    bit_count_nxt  = bit_count_r;
    tx_shift_nxt   = tx_shift_r;
    rx_shift_nxt   = rx_shift_r;
    is_read_nxt    = is_read_r;
    enable_nxt     = enable_r;
    clock_nxt      = clock_r;
    data_nxt       = data_r;
    driving_nxt    = driving_r;
    last_read_nxt  = last_read_r;
    rejected       = 1'b0;
    done           = 1'b0;
    start_bit      = 1'b0;
    bit_idx        = bit_count_r;

    if (item.cmd == CMD_READ || item.cmd == CMD_WRITE) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        is_read_nxt = (item.cmd == CMD_READ);
        if (item.cmd == CMD_READ) begin
          tx_shift_nxt = {8'd0, {1'b0, item.reg_addr & ADDR_MASK, 1'b0} | CMD_BYTE_RD};
        end else begin
          tx_shift_nxt = {item.write_data,
                          {1'b0, item.reg_addr & ADDR_MASK, 1'b0} | CMD_BYTE_WR};
        end
        rx_shift_nxt   = 8'd0;
        bit_count_nxt  = 5'd0;
        enable_nxt     = 1'b1;
        clock_nxt      = 1'b0;
        wait_timer_nxt = at_least_one(cfg.setup_ticks);
        phase_nxt      = PH_SETUP;
      end
    end else if (item.cmd == CMD_TICK && phase_r != PH_IDLE) begin
      wait_timer_nxt = timer_dec;
      if (timer_dec == 8'd0) begin
        unique case (phase_r)
          PH_SETUP: begin
            bit_count_nxt = 5'd0;
            bit_idx       = 5'd0;
            start_bit     = 1'b1;
          end
          PH_HIGH: begin
            clock_nxt      = 1'b0;
            wait_timer_nxt = at_least_one(cfg.low_ticks);
            phase_nxt      = PH_LOW;
          end
          PH_LOW: begin
            bit_count_nxt = bit_count_r + 5'd1;
            bit_idx       = bit_count_r + 5'd1;
            if (bit_idx >= BITS_PER_ACC) begin
              enable_nxt     = 1'b0;
              wait_timer_nxt = at_least_one(cfg.hold_ticks);
              phase_nxt      = PH_HOLD;
            end else begin
              start_bit = 1'b1;
            end
          end
          default: begin
            if (is_read_r) begin
              last_read_nxt = rx_shift_r;
            end
            driving_nxt = 1'b0;
            data_nxt    = 1'b0;
            done        = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        endcase
      end
    end

    // Present the next bit on the rising clock; sample reply bits on it too
    if (start_bit) begin
      if (is_read_r && bit_idx >= BITS_PER_BYTE) begin
        driving_nxt  = 1'b0;
        data_nxt     = 1'b0;
        rx_shift_nxt = rx_shift_r | ({7'd0, item.io_sample} << bit_idx[2:0]);
      end else begin
        driving_nxt = 1'b1;
        data_nxt    = tx_shift_r[bit_idx[3:0]];
      end
      clock_nxt      = 1'b1;
      wait_timer_nxt = at_least_one(cfg.high_ticks);
      phase_nxt      = PH_HIGH;
    end
  end

  assign result.enable_pin     = enable_nxt;
  assign result.clock_pin      = clock_nxt;
  assign result.io_drive_level = driving_nxt && data_nxt;
  assign result.io_driving     = driving_nxt;
  assign result.busy_res       = (phase_nxt != PH_IDLE);
  assign result.done_res       = done;
  assign result.read_byte      = last_read_nxt;
  assign result.rejected       = rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_timer_r <= 8'd0;
      bit_count_r  <= 5'd0;
      tx_shift_r   <= 16'd0;
      rx_shift_r   <= 8'd0;
      is_read_r    <= 1'b0;
      enable_r     <= 1'b0;
      clock_r      <= 1'b0;
      data_r       <= 1'b0;
      driving_r    <= 1'b0;
      last_read_r  <= 8'd0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      wait_timer_r <= wait_timer_nxt;
      bit_count_r  <= bit_count_nxt;
      tx_shift_r   <= tx_shift_nxt;
      rx_shift_r   <= rx_shift_nxt;
      is_read_r    <= is_read_nxt;
      enable_r     <= enable_nxt;
      clock_r      <= clock_nxt;
      data_r       <= data_nxt;
      driving_r    <= driving_nxt;
      last_read_r  <= last_read_nxt;
    end
  end

endmodule

>>> dv/three_wire_rtc_byte_master_test.sv
// Self-checking testbench for the three-wire clock-chip byte master.
// Drives request and tick transactions, predicts every status word and compares
// each result field by field. Depends on rtc3w_pkg and three_wire_rtc_byte_master.
`timescale 1ns / 1ps

module three_wire_rtc_byte_master_test;
  import rtc3w_pkg::*;

  // Command value three does nothing; the package has no name for it.
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SCRIPT_LEN = 9;

  // Status word as it sits on out_tdata, lowest bit last.
  typedef struct packed {
    logic       pad;
    logic       rejected;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       io_driving;
    logic       io_drive_level;
    logic       clock_pin;
    logic       enable_pin;
  } status_word_t;

  // One row of the directed script: the input fields, and where the status
  // word is obvious, the word itself typed in.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  reg_addr;
    logic [7:0]  write_data;
    logic        io_sample;
    logic        typed;
    logic [15:0] word;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  three_wire_rtc_byte_master uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer prediction: a private copy of the tick counts and of the access
  // state, stepped once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_setup, cfg_high, cfg_low, cfg_hold;
  logic [3:0]  seq_phase;
  logic [7:0]  seq_timer;
  logic [4:0]  seq_bit;
  logic [15:0] seq_tx;
  logic [7:0]  seq_rx;
  logic        seq_rd;
  logic        pin_en, pin_clk, pin_dat, pin_drv;
  logic [7:0]  last_rd_byte;

  status_word_t expected_pins[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_gap_pct = 0;
  int unsigned  stall_pct = 0;

  function automatic logic [7:0] min_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic void reset_model();
    cfg_setup    = 8'd4;
    cfg_high     = 8'd1;
    cfg_low      = 8'd1;
    cfg_hold     = 8'd4;
    seq_phase    = PH_IDLE;
    seq_timer    = '0;
    seq_bit      = '0;
    seq_tx       = '0;
    seq_rx       = '0;
    seq_rd       = 1'b0;
    pin_en       = 1'b0;
    pin_clk      = 1'b0;
    pin_dat      = 1'b0;
    pin_drv      = 1'b0;
    last_rd_byte = '0;
  endfunction

  // Raise the clock for the current bit: present a command/data bit, or for
  // the data half of a read release the line and capture the sampled level.
  function automatic void start_bit(input logic smp);
    if (seq_rd && seq_bit >= BITS_PER_BYTE) begin
      pin_drv = 1'b0;
      pin_dat = 1'b0;
      seq_rx[seq_bit[2:0]] = seq_rx[seq_bit[2:0]] | smp;
    end else begin
      pin_drv = 1'b1;
      pin_dat = seq_tx[seq_bit[3:0]];
    end
    pin_clk   = 1'b1;
    seq_timer = min_one(cfg_high);
    seq_phase = PH_HIGH;
  endfunction

  function automatic status_word_t advance_sequencer(input rtc3w_item_t it);
    status_word_t w;
    logic rej;
    logic done;
    rej  = 1'b0;
    done = 1'b0;
    if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
      if (seq_phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        seq_rd = (it.cmd == CMD_READ);
        if (seq_rd)
          seq_tx = {8'h00, ({1'b0, it.reg_addr, 1'b0} | CMD_BYTE_RD)};
        else
          seq_tx = {it.write_data, ({1'b0, it.reg_addr, 1'b0} | CMD_BYTE_WR)};
        seq_rx    = '0;
        seq_bit   = '0;
        pin_en    = 1'b1;
        pin_clk   = 1'b0;
        seq_timer = min_one(cfg_setup);
        seq_phase = PH_SETUP;
      end
    end else if (it.cmd == CMD_TICK && seq_phase != PH_IDLE) begin
      seq_timer = seq_timer - 8'd1;
      if (seq_timer == 8'd0) begin
        case (seq_phase)
          PH_SETUP: begin
            seq_bit = '0;
            start_bit(it.io_sample);
          end
          PH_HIGH: begin
            pin_clk   = 1'b0;
            seq_timer = min_one(cfg_low);
            seq_phase = PH_LOW;
          end
          PH_LOW: begin
            seq_bit = seq_bit + 5'd1;
            if (seq_bit >= BITS_PER_ACC) begin
              pin_en    = 1'b0;
              seq_timer = min_one(cfg_hold);
              seq_phase = PH_HOLD;
            end else begin
              start_bit(it.io_sample);
            end
          end
          default: begin
            if (seq_rd)
              last_rd_byte = seq_rx;
            pin_drv   = 1'b0;
            pin_dat   = 1'b0;
            done      = 1'b1;
            seq_phase = PH_IDLE;
          end
        endcase
      end
    end
    w.pad            = 1'b0;
    w.rejected       = rej;
    w.read_byte      = last_rd_byte;
    w.done_res       = done;
    w.busy_res       = (seq_phase != PH_IDLE);
    w.io_driving     = pin_drv;
    w.io_drive_level = pin_drv & pin_dat;
    w.clock_pin      = pin_clk;
    w.enable_pin     = pin_en;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script, run under the reset tick counts (setup 4, high 1, low 1,
  // hold 4). Typed words: 16'h0011 is enable plus busy, 16'h4011 adds rejected.
  // ---------------------------------------------------------------------------
  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_TICK,  6'h00, 8'h00, 1'b1, 1'b1, 16'h0000},  // tick while idle: no change
    '{CMD_NOP,   6'h3f, 8'hff, 1'b1, 1'b1, 16'h0000},  // command three while idle
    '{CMD_WRITE, 6'h3f, 8'hff, 1'b0, 1'b1, 16'h0011},  // top address, all-ones data
    '{CMD_READ,  6'h00, 8'h00, 1'b0, 1'b1, 16'h4011},  // read while busy: rejected
    '{CMD_WRITE, 6'h15, 8'h5a, 1'b1, 1'b1, 16'h4011},  // write while busy: rejected
    '{CMD_NOP,   6'h2a, 8'h00, 1'b0, 1'b1, 16'h0011},  // command three while busy
    '{CMD_TICK,  6'h00, 8'h00, 1'b1, 1'b0, 16'h0000},
    '{CMD_TICK,  6'h3f, 8'hff, 1'b0, 1'b0, 16'h0000},
    '{CMD_TICK,  6'h00, 8'h00, 1'b1, 1'b0, 16'h0000}
  };

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sender gap and receiver stall rates for the current stretch of the run.
  task automatic set_idling(input int unsigned mode);
    case (mode)
      0:       begin send_gap_pct = 25; stall_pct = 85; end
      1:       begin send_gap_pct = 85; stall_pct = 25; end
      default: begin send_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Drive one input transaction, hold it until accepted, then queue the
  // status word it must produce: the typed word if given, else the prediction.
  task automatic send_item(input rtc3w_item_t it, input logic typed, input logic [15:0] word);
    status_word_t pred;
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {1'b0, it.io_sample, it.write_data, it.reg_addr};
    do @(posedge clk); while (!in_tready);
    pred = advance_sequencer(it);
    expected_pins.push_back(typed ? status_word_t'(word) : pred);
  endtask

  // Tick the current access to completion; level 0 or 1 holds the sampled
  // data pin there, anything else randomizes it.
  task automatic finish_access(input int unsigned level);
    rtc3w_item_t it;
    while (seq_phase != PH_IDLE) begin
      it.cmd        = CMD_TICK;
      it.reg_addr   = 6'($urandom_range(63));
      it.write_data = 8'($urandom_range(255));
      it.io_sample  = (level > 1) ? 1'($urandom_range(1)) : 1'(level);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Drop valid and wait until every queued status word has come back.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  // Write all four tick counts, one register per cycle; only call when idle.
  task automatic load_config(input logic [7:0] setup_t, input logic [7:0] high_t,
                             input logic [7:0] low_t, input logic [7:0] hold_t);
    logic [1:0] regs [4];
    logic [7:0] vals [4];
    regs = '{CFG_SETUP, CFG_HIGH, CFG_LOW, CFG_HOLD};
    vals = '{setup_t, high_t, low_t, hold_t};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cfg_setup = setup_t;
    cfg_high  = high_t;
    cfg_low   = low_t;
    cfg_hold  = hold_t;
  endtask

  // Mostly short tick counts so accesses stay quick; now and then a longer one.
  function automatic logic [7:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(3));
    if (r < 95) return 8'($urandom_range(6, 4));
    return 8'($urandom_range(12, 7));
  endfunction

  // Random traffic shaped as real accesses: when idle mostly start one, when
  // busy mostly tick it along, with rejected requests and no-ops as noise.
  // Only transactions that move the sequencer count toward n.
  task automatic random_run(input int unsigned n);
    rtc3w_item_t it;
    int unsigned counted;
    int unsigned r;
    logic idle;
    logic ignored;
    counted = 0;
    while (counted < n) begin
      idle          = (seq_phase == PH_IDLE);
      r             = $urandom_range(99);
      it.reg_addr   = 6'($urandom_range(63));
      it.write_data = 8'($urandom_range(255));
      it.io_sample  = 1'($urandom_range(1));
      if (idle)
        it.cmd = (r < 80) ? ($urandom_range(1) ? CMD_READ : CMD_WRITE) :
                 (r < 90) ? CMD_TICK : CMD_NOP;
      else
        it.cmd = (r < 88) ? CMD_TICK :
                 (r < 95) ? ($urandom_range(1) ? CMD_READ : CMD_WRITE) : CMD_NOP;
      ignored = (it.cmd == CMD_NOP) || (idle == (it.cmd == CMD_TICK));
      send_item(it, 1'b0, '0);
      if (!ignored)
        counted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the field-by-field comparison.
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  status_word_t want_w, got_w;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_w = status_word_t'(out_tdata);
      if (expected_pins.size() == 0) begin
        $error("status word %h arrived with nothing expected", out_tdata);
        mismatches++;
      end else begin
        want_w = expected_pins.pop_front();
        check_field("enable_pin",     8'(want_w.enable_pin),     8'(got_w.enable_pin));
        check_field("clock_pin",      8'(want_w.clock_pin),      8'(got_w.clock_pin));
        check_field("io_drive_level", 8'(want_w.io_drive_level), 8'(got_w.io_drive_level));
        check_field("io_driving",     8'(want_w.io_driving),     8'(got_w.io_driving));
        check_field("busy_res",       8'(want_w.busy_res),       8'(got_w.busy_res));
        check_field("done_res",       8'(want_w.done_res),       8'(got_w.done_res));
        check_field("read_byte",      want_w.read_byte,          got_w.read_byte);
        check_field("rejected",       8'(want_w.rejected),       8'(got_w.rejected));
        check_field("pad",            8'(want_w.pad),            8'(got_w.pad));
      end
    end
  end

  // Hard stop if the handshakes ever hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rtc3w_item_t it;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // Reset tick counts, written back explicitly.
    load_config(8'd4, 8'd1, 8'd1, 8'd4);

    // Walk the directed script, then finish the write it started.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      it.cmd        = script[i].cmd;
      it.reg_addr   = script[i].reg_addr;
      it.write_data = script[i].write_data;
      it.io_sample  = script[i].io_sample;
      send_item(it, script[i].typed, script[i].word);
    end
    finish_access(2);

    // Reads with the data pin held high, then low: all-ones and all-zeros bytes.
    it = '{cmd: CMD_READ, reg_addr: 6'h00, write_data: 8'h00, io_sample: 1'b1};
    send_item(it, 1'b0, '0);
    finish_access(1);
    it = '{cmd: CMD_READ, reg_addr: 6'h2a, write_data: 8'hff, io_sample: 1'b0};
    send_item(it, 1'b0, '0);
    finish_access(0);
    // Bottom address with all-zeros data.
    it = '{cmd: CMD_WRITE, reg_addr: 6'h00, write_data: 8'h00, io_sample: 1'b0};
    send_item(it, 1'b0, '0);
    finish_access(2);
    quiesce();

    // Random phases: zero counts (taken as one), minimum counts, then random
    // counts; idling pattern advances every three phases.
    for (int unsigned ph = 0; ph < 9; ph++) begin
      set_idling(ph / 3);
      case (ph)
        0:       load_config(8'd0, 8'd0, 8'd0, 8'd0);
        1:       load_config(8'd1, 8'd1, 8'd1, 8'd1);
        default: load_config(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      endcase
      random_run(26);
      finish_access(2);
      quiesce();
    end

    // Longest setup count runs the wait timer through its full range; keep
    // the other counts short so the access stays a few hundred ticks.
    load_config(8'd255, 8'd1, 8'd1, 8'd1);
    random_run(6);
    finish_access(2);
    quiesce();

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
